// ===== sv/quadrotor_motor_mixer_assert.svh =====
// Assertion helpers shared by the mixer modules. Every check is sampled on
// the rising clock edge and is switched off while reset is high.
`ifndef QUADROTOR_MOTOR_MIXER_ASSERT_SVH
`define QUADROTOR_MOTOR_MIXER_ASSERT_SVH

// A property that must hold on every edge outside reset.
`define QMM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define QMM_ASSERT_NOW(label, ante, cons, msg) \
   `QMM_ASSERT(label, (ante) |-> (cons), msg)

// A consequence that must hold in the cycle after its cause.
`define QMM_ASSERT_NEXT(label, ante, cons, msg) \
   `QMM_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ===== sv/qmm_pkg.sv =====
`default_nettype none

package qmm_pkg;

   // Port widths.
   localparam int IN_W       = 32;
   localparam int OUT_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int GAIN_W     = 32;
   localparam int COEF_W     = 24;
   localparam int MOTORS     = 4;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_INV_K         = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_INV_TWO_ARM   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_INV_FOUR_DRAG = CSR_IDX_W'(2);

   // Mixing: thrust/4 in Q.16 equals thrust shifted into Q.32 by 14 bits.
   localparam int THRUST_SHIFT = 14;
   localparam int THRUST_W     = IN_W + THRUST_SHIFT;
   localparam int TORQUE_W     = IN_W + COEF_W;
   localparam int MIX_W        = TORQUE_W + 2;
   localparam int MAG_W        = MIX_W - 1;

   // Gain product, split in two partial products.
   localparam int LO_W      = 32;
   localparam int HI_W      = MAG_W - LO_W;
   localparam int LO_PROD_W = LO_W + GAIN_W;
   localparam int HI_PROD_W = HI_W + GAIN_W;
   localparam int CAP_EXP   = 62;
   localparam int HI_KEEP   = CAP_EXP - LO_W;
   localparam int SUM_W     = LO_PROD_W + 1;
   localparam logic [SUM_W-1:0] SUM_CAP = SUM_W'(1) << CAP_EXP;
   localparam int RAD_SHIFT = 8;
   localparam int RAD_W     = CAP_EXP - RAD_SHIFT + 1;
   localparam logic [RAD_W-1:0] RAD_CAP = RAD_W'(1) << (RAD_W - 1);

   // Square root, two result bits per cycle.
   localparam int ROOT_W    = (RAD_W + 1) / 2;
   localparam int REM_W     = ROOT_W + 2;
   localparam int SQ_STEPS  = 2;
   localparam int SQ_CYCLES = ROOT_W / SQ_STEPS;
   localparam int SQ_CNT_W  = $clog2(SQ_CYCLES);
   localparam logic [SQ_CNT_W-1:0] SQ_LAST = SQ_CNT_W'(SQ_CYCLES - 1);

   // Queue between the front and the back.
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // PWM mapping.
   localparam int PWM_OFFSET = 667;
   localparam int PWM_LOW    = 1075;
   localparam int PWM_HIGH   = 1950;
   localparam int FRAC_ONE   = 65536;
   localparam int Q14_ONE    = 16384;
   localparam int SPAN       = (PWM_HIGH - PWM_LOW) * 4;
   localparam int NUM_BIAS   = (PWM_LOW + PWM_HIGH - 2 * PWM_OFFSET) * FRAC_ONE;
   localparam int ROOT_LO_SAT = (NUM_BIAS - SPAN * Q14_ONE) / 2;
   localparam int ROOT_HI_SAT = (NUM_BIAS + SPAN * Q14_ONE) / 2;
   localparam int X_BIAS      = 2 * ROOT_LO_SAT;
   localparam int X_W         = 27;
   localparam int RECIP_SHIFT = 40;
   localparam int RECIP_W     = 29;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / SPAN);
   localparam int PROD_W = X_W + RECIP_W;
   localparam int QUO_W  = 15;
   localparam int RES_W  = 13;

   typedef logic [MOTORS-1:0][RAD_W-1:0] rad_set_type;

   typedef struct packed {
      logic        valid;
      rad_set_type rad;
   } rad_req_type;

   typedef struct packed {
      logic                           valid;
      logic [MOTORS-1:0][ROOT_W-1:0]  root;
   } root_res_type;

   typedef struct packed {
      logic                          valid;
      logic [MOTORS-1:0][OUT_W-1:0]  motor;
   } drive_type;

   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sq_state_type;

   // One digit of the restoring square root: bring down two radicand bits
   // and try to append a one to the partial root.
   function automatic sq_state_type sq_step(input sq_state_type cur,
                                            input logic [1:0] pair);
      logic [REM_W+1:0] rem2;
      logic [REM_W+1:0] trial;
      logic [REM_W+1:0] diff;
      sq_state_type     nxt;
      rem2  = {cur.rem, pair};
      trial = {2'b00, cur.root, 2'b01};
      diff  = rem2 - trial;
      if (rem2 >= trial) begin
         nxt.rem  = diff[REM_W-1:0];
         nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
      end else begin
         nxt.rem  = rem2[REM_W-1:0];
         nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
      end
      return nxt;
   endfunction

endpackage

`default_nettype wire

// ===== sv/qmm_front.sv =====
`default_nettype none

module qmm_front import qmm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic signed [IN_W-1:0] req_thrust,
   input  logic signed [IN_W-1:0] req_roll_torque,
   input  logic signed [IN_W-1:0] req_pitch_torque,
   input  logic signed [IN_W-1:0] req_yaw_torque,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output rad_req_type            push,
   input  logic                   q_full
);

   logic [GAIN_W-1:0] inv_k_ff, inv_k_in;
   logic [COEF_W-1:0] inv_two_arm_ff, inv_two_arm_in;
   logic [COEF_W-1:0] inv_four_drag_ff, inv_four_drag_in;

   logic advance;
   logic accept;

   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;
   logic s4_valid_ff, s4_valid_in;

   logic signed [THRUST_W-1:0] s1_thrust_ff, s1_thrust_in;
   logic signed [TORQUE_W-1:0] s1_roll_ff, s1_roll_in;
   logic signed [TORQUE_W-1:0] s1_pitch_ff, s1_pitch_in;
   logic signed [TORQUE_W-1:0] s1_yaw_ff, s1_yaw_in;
   logic signed [TORQUE_W:0]   roll_full, pitch_full, yaw_full;

   logic signed [MIX_W-1:0] t_ext, r_ext, p_ext, y_ext;
   logic signed [MIX_W-1:0] mix0, mix1, mix2, mix3;
   logic [MOTORS-1:0][MAG_W-1:0] s2_mag_ff, s2_mag_in;

   logic [MOTORS-1:0][LO_PROD_W-1:0] s3_lo_ff, s3_lo_in;
   logic [MOTORS-1:0][HI_PROD_W-1:0] s3_hi_ff, s3_hi_in;

   rad_set_type s4_rad_ff, s4_rad_in;

   // Configuration registers.
   always_comb begin
      inv_k_in         = inv_k_ff;
      inv_two_arm_in   = inv_two_arm_ff;
      inv_four_drag_in = inv_four_drag_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_INV_K:         inv_k_in         = csr_wdata[GAIN_W-1:0];
            CSR_INV_TWO_ARM:   inv_two_arm_in   = csr_wdata[COEF_W-1:0];
            CSR_INV_FOUR_DRAG: inv_four_drag_in = csr_wdata[COEF_W-1:0];
            default: ;
         endcase
      end
   end

   // The whole pipe holds while the last stage waits for room in the queue.
   assign advance = !s4_valid_ff || !q_full;
   assign busy    = !advance;
   assign accept  = start && advance;

   assign s1_valid_in = advance ? accept      : s1_valid_ff;
   assign s2_valid_in = advance ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = advance ? s2_valid_ff : s3_valid_ff;
   assign s4_valid_in = advance ? s3_valid_ff : s4_valid_ff;

   // Stage 1: torque products.
   assign roll_full    = req_roll_torque * $signed({1'b0, inv_two_arm_ff});
   assign pitch_full   = req_pitch_torque * $signed({1'b0, inv_two_arm_ff});
   assign yaw_full     = req_yaw_torque * $signed({1'b0, inv_four_drag_ff});
   assign s1_thrust_in = {req_thrust, {THRUST_SHIFT{1'b0}}};
   assign s1_roll_in   = roll_full[TORQUE_W-1:0];
   assign s1_pitch_in  = pitch_full[TORQUE_W-1:0];
   assign s1_yaw_in    = yaw_full[TORQUE_W-1:0];

   // Stage 2: plus-layout mix, negative demands clamp to zero.
   assign t_ext = {{(MIX_W-THRUST_W){s1_thrust_ff[THRUST_W-1]}}, s1_thrust_ff};
   assign r_ext = {{(MIX_W-TORQUE_W){s1_roll_ff[TORQUE_W-1]}}, s1_roll_ff};
   assign p_ext = {{(MIX_W-TORQUE_W){s1_pitch_ff[TORQUE_W-1]}}, s1_pitch_ff};
   assign y_ext = {{(MIX_W-TORQUE_W){s1_yaw_ff[TORQUE_W-1]}}, s1_yaw_ff};
   assign mix0  = t_ext - r_ext - y_ext;
   assign mix1  = t_ext + r_ext - y_ext;
   assign mix2  = t_ext - p_ext + y_ext;
   assign mix3  = t_ext + p_ext + y_ext;
   assign s2_mag_in[0] = mix0[MIX_W-1] ? '0 : mix0[MAG_W-1:0];
   assign s2_mag_in[1] = mix1[MIX_W-1] ? '0 : mix1[MAG_W-1:0];
   assign s2_mag_in[2] = mix2[MIX_W-1] ? '0 : mix2[MAG_W-1:0];
   assign s2_mag_in[3] = mix3[MIX_W-1] ? '0 : mix3[MAG_W-1:0];

   // Stage 3: partial products of the demand with the gain.
   always_comb begin
      for (int k = 0; k < MOTORS; k++) begin
         s3_lo_in[k] = s2_mag_ff[k][LO_W-1:0] * inv_k_ff;
         s3_hi_in[k] = s2_mag_ff[k][MAG_W-1:LO_W] * inv_k_ff;
      end
   end

   // Stage 4: combine, cap at 2^62 and drop the low byte.
   always_comb begin
      logic [SUM_W-1:0] sum;
      sum = '0;
      for (int k = 0; k < MOTORS; k++) begin
         sum = {{(SUM_W-HI_KEEP-LO_W){1'b0}}, s3_hi_ff[k][HI_KEEP-1:0], {LO_W{1'b0}}}
               + {1'b0, s3_lo_ff[k]};
         if (s3_hi_ff[k][HI_PROD_W-1:HI_KEEP] != '0 || sum > SUM_CAP) begin
            s4_rad_in[k] = RAD_CAP;
         end else begin
            s4_rad_in[k] = sum[CAP_EXP:RAD_SHIFT];
         end
      end
   end

   assign push.valid = s4_valid_ff;
   assign push.rad   = s4_rad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_k_ff         <= '0;
         inv_two_arm_ff   <= '0;
         inv_four_drag_ff <= '0;
         s1_valid_ff      <= 1'b0;
         s2_valid_ff      <= 1'b0;
         s3_valid_ff      <= 1'b0;
         s4_valid_ff      <= 1'b0;
      end else begin
         inv_k_ff         <= inv_k_in;
         inv_two_arm_ff   <= inv_two_arm_in;
         inv_four_drag_ff <= inv_four_drag_in;
         s1_valid_ff      <= s1_valid_in;
         s2_valid_ff      <= s2_valid_in;
         s3_valid_ff      <= s3_valid_in;
         s4_valid_ff      <= s4_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_thrust_ff <= s1_thrust_in;
         s1_roll_ff   <= s1_roll_in;
         s1_pitch_ff  <= s1_pitch_in;
         s1_yaw_ff    <= s1_yaw_in;
         s2_mag_ff    <= s2_mag_in;
         s3_lo_ff     <= s3_lo_in;
         s3_hi_ff     <= s3_hi_in;
         s4_rad_ff    <= s4_rad_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/qmm_queue.sv =====
`default_nettype none
`include "quadrotor_motor_mixer_assert.svh"

module qmm_queue import qmm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  rad_req_type push,
   output logic        full,
   input  logic        pop,
   output rad_req_type head
);

   rad_set_type ent_ff [QDEPTH];
   rad_set_type ent_in;
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic do_push;
   logic do_pop;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full    = (count_ff == QCNT_W'(QDEPTH));
   assign do_push = push.valid && !full;
   assign do_pop  = pop && (count_ff != '0);
   assign ent_in  = push.rad;

   assign head.valid = (count_ff != '0);
   assign head.rad   = ent_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         ent_ff[wr_ptr_ff] <= ent_in;
      end
   end

   `QMM_ASSERT(qmm_queue_bound, count_ff <= QCNT_W'(QDEPTH), "queue holds more than its depth")
   `QMM_ASSERT_NOW(qmm_queue_pop, pop, count_ff != '0, "pop from an empty queue")

endmodule

`default_nettype wire

// ===== sv/qmm_root.sv =====
`default_nettype none
`include "quadrotor_motor_mixer_assert.svh"

module qmm_root import qmm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  rad_req_type  head,
   output logic         pop,
   output root_res_type res
);

   logic run_ff, run_in;
   logic [SQ_CNT_W-1:0] cnt_ff, cnt_in;
   logic [MOTORS-1:0][2*ROOT_W-1:0] rad_ff, rad_in;
   sq_state_type [MOTORS-1:0] sq_ff, sq_in, sq_next;
   logic res_valid_ff, res_valid_in;
   logic [MOTORS-1:0][ROOT_W-1:0] res_root_ff, res_root_in;
   logic finish;
   logic load;

   // The next radicand set is taken in the same cycle the last digits retire.
   assign finish = run_ff && (cnt_ff == SQ_LAST);
   assign load   = head.valid && (!run_ff || finish);
   assign pop    = load;

   always_comb begin
      sq_state_type st;
      st = '0;
      for (int k = 0; k < MOTORS; k++) begin
         st = sq_ff[k];
         for (int j = 0; j < SQ_STEPS; j++) begin
            st = sq_step(st, rad_ff[k][2*ROOT_W-1-2*j -: 2]);
         end
         sq_next[k] = st;
      end
   end

   always_comb begin
      run_in = run_ff;
      cnt_in = cnt_ff;
      rad_in = rad_ff;
      sq_in  = sq_ff;
      if (load) begin
         run_in = 1'b1;
         cnt_in = '0;
         sq_in  = '0;
         for (int k = 0; k < MOTORS; k++) begin
            rad_in[k] = {{(2*ROOT_W-RAD_W){1'b0}}, head.rad[k]};
         end
      end else if (run_ff) begin
         run_in = !finish;
         cnt_in = cnt_ff + 1'b1;
         sq_in  = sq_next;
         for (int k = 0; k < MOTORS; k++) begin
            rad_in[k] = rad_ff[k] << (2 * SQ_STEPS);
         end
      end
      res_valid_in = finish;
      for (int k = 0; k < MOTORS; k++) begin
         res_root_in[k] = sq_next[k].root;
      end
   end

   assign res.valid = res_valid_ff;
   assign res.root  = res_root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= 1'b0;
         cnt_ff       <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         run_ff       <= run_in;
         cnt_ff       <= cnt_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff      <= rad_in;
      sq_ff       <= sq_in;
      res_root_ff <= res_root_in;
   end

   `QMM_ASSERT_NEXT(qmm_root_count, run_ff && !finish,
                    run_ff && cnt_ff == $past(cnt_ff) + 1'b1, "root iteration count skipped")

endmodule

`default_nettype wire

// ===== sv/qmm_scale.sv =====
`default_nettype none
`include "quadrotor_motor_mixer_assert.svh"

module qmm_scale import qmm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  root_res_type root_in,
   output drive_type    drv
);

   localparam int MAP_STAGES = 4;

   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, v4_ff, v4_in;
   logic [MOTORS-1:0] lo1_ff, lo1_in, hi1_ff, hi1_in;
   logic [MOTORS-1:0] lo2_ff, hi2_ff, lo3_ff, hi3_ff;
   logic [MOTORS-1:0][X_W-1:0] x1_ff, x1_in, x2_ff;
   logic [MOTORS-1:0][PROD_W-1:0] prod2_ff, prod2_in;
   logic [MOTORS-1:0][QUO_W-1:0] q3_ff, q3_in;
   logic [MOTORS-1:0][RES_W-1:0] r3_ff, r3_in;
   logic [MOTORS-1:0][OUT_W-1:0] motor_ff, motor_in;

   assign v1_in = root_in.valid;
   assign v2_in = v1_ff;
   assign v3_in = v2_ff;
   assign v4_in = v3_ff;

   // Stage 1: x = 2*width - 3025.0 + 1.0 full scale, plus saturation flags.
   always_comb begin
      logic [ROOT_W+1:0] xf;
      xf = '0;
      for (int k = 0; k < MOTORS; k++) begin
         xf = {1'b0, root_in.root[k], 1'b0} - (ROOT_W+2)'(X_BIAS);
         x1_in[k]  = xf[X_W-1:0];
         lo1_in[k] = (root_in.root[k] <= ROOT_W'(ROOT_LO_SAT));
         hi1_in[k] = (root_in.root[k] >= ROOT_W'(ROOT_HI_SAT));
      end
   end

   // Stage 2: quotient estimate by the span reciprocal.
   always_comb begin
      for (int k = 0; k < MOTORS; k++) begin
         prod2_in[k] = x1_ff[k] * RECIP;
      end
   end

   // Stage 3: the estimate is exact or one short; keep the remainder to tell.
   always_comb begin
      logic [X_W-1:0] qs;
      logic [X_W-1:0] diff;
      qs   = '0;
      diff = '0;
      for (int k = 0; k < MOTORS; k++) begin
         q3_in[k] = prod2_ff[k][RECIP_SHIFT+QUO_W-1:RECIP_SHIFT];
         qs       = X_W'(q3_in[k]) * X_W'(SPAN);
         diff     = x2_ff[k] - qs;
         r3_in[k] = diff[RES_W-1:0];
      end
   end

   // Stage 4: correct and saturate.
   always_comb begin
      logic [OUT_W-1:0] quo;
      quo = '0;
      for (int k = 0; k < MOTORS; k++) begin
         quo = {1'b0, q3_ff[k]} + OUT_W'(r3_ff[k] >= RES_W'(SPAN));
         priority if (lo3_ff[k]) begin
            motor_in[k] = OUT_W'(-Q14_ONE);
         end else if (hi3_ff[k]) begin
            motor_in[k] = OUT_W'(Q14_ONE);
         end else begin
            motor_in[k] = quo - OUT_W'(Q14_ONE);
         end
      end
   end

   assign drv.valid = v4_ff;
   assign drv.motor = motor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      lo1_ff   <= lo1_in;
      hi1_ff   <= hi1_in;
      x1_ff    <= x1_in;
      lo2_ff   <= lo1_ff;
      hi2_ff   <= hi1_ff;
      x2_ff    <= x1_ff;
      prod2_ff <= prod2_in;
      lo3_ff   <= lo2_ff;
      hi3_ff   <= hi2_ff;
      q3_ff    <= q3_in;
      r3_ff    <= r3_in;
      motor_ff <= motor_in;
   end

   `QMM_ASSERT_NOW(qmm_scale_latency, v4_ff, $past(root_in.valid, MAP_STAGES),
                   "drive strobe without a root")

endmodule

`default_nettype wire

// ===== sv/quadrotor_motor_mixer.sv =====
// Plus-layout quadrotor motor mixer. A request (thrust and roll, pitch and
// yaw torques, signed Q15.16) is taken on a clock edge where start is high
// and busy is low; it yields exactly one result, four motor drives in Q2.14
// saturated to -1.0..+1.0, shown on the rsp_ ports for a single cycle while
// rsp_valid is high. The receiver cannot hold results off, so it must take
// every strobe. An accepted request passes through the mixing front, the
// queue, the square root unit and the mapping stages. The square root unit
// retires two root bits per cycle over 28 bits, one radicand set at a time;
// a four-stage mixing front and a two-entry queue take a short burst of
// requests at one per cycle before busy rises. Write the gain registers only
// while no request is in flight.
`default_nettype none

module quadrotor_motor_mixer import qmm_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic signed [IN_W-1:0]  req_thrust,
   input  logic signed [IN_W-1:0]  req_roll_torque,
   input  logic signed [IN_W-1:0]  req_pitch_torque,
   input  logic signed [IN_W-1:0]  req_yaw_torque,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   output logic                    rsp_valid,
   output logic signed [OUT_W-1:0] rsp_motor_front,
   output logic signed [OUT_W-1:0] rsp_motor_back,
   output logic signed [OUT_W-1:0] rsp_motor_left,
   output logic signed [OUT_W-1:0] rsp_motor_right
);

   rad_req_type  push;
   rad_req_type  head;
   logic         q_full;
   logic         pop;
   root_res_type root_res;
   drive_type    drv;

   qmm_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_thrust       (req_thrust),
      .req_roll_torque  (req_roll_torque),
      .req_pitch_torque (req_pitch_torque),
      .req_yaw_torque   (req_yaw_torque),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .push             (push),
      .q_full           (q_full)
   );

   qmm_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (q_full),
      .pop   (pop),
      .head  (head)
   );

   qmm_root u_root (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .res   (root_res)
   );

   qmm_scale u_scale (
      .clock   (clock),
      .reset   (reset),
      .root_in (root_res),
      .drv     (drv)
   );

   assign rsp_valid       = drv.valid;
   assign rsp_motor_front = drv.motor[0];
   assign rsp_motor_back  = drv.motor[1];
   assign rsp_motor_left  = drv.motor[2];
   assign rsp_motor_right = drv.motor[3];

endmodule

`default_nettype wire
